// ===== src/ldq_pkg.sv =====
// Package with the opcodes, status codes and sequencer state type of the linked deque.
package ldq_pkg;
   localparam int OPCODE_WIDTH = 3;
   localparam int VALUE_WIDTH  = 32;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE     = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_FULL       = 2'd2,
      ST_BAD_HANDLE = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_LINK  = 5'b00100,
      S_WRITE = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;
endpackage

// ===== src/ldq_if.sv =====
// Valid/ready channel interfaces for requests and responses of the linked deque.
interface ldq_req_if #(parameter int HANDLE_WIDTH = 5);
   logic                     valid;
   logic                     ready;
   logic [2:0]               opcode;
   logic signed [31:0]       value;
   logic [HANDLE_WIDTH-1:0]  handle;
   modport source (output valid, opcode, value, handle, input ready);
   modport sink   (input valid, opcode, value, handle, output ready);
endinterface

interface ldq_rsp_if #(parameter int HANDLE_WIDTH = 5);
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       popped_value;
   logic [HANDLE_WIDTH-1:0]  new_handle;
   logic [1:0]               status;
   logic [HANDLE_WIDTH-1:0]  count;
   logic                     is_empty;
   modport source (output valid, popped_value, new_handle, status, count, is_empty,
                   input ready);
   modport sink   (input valid, popped_value, new_handle, status, count, is_empty,
                   output ready);
endinterface

// ===== src/ldq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ldq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/linked_deque_with_handle_remove_top.sv =====
// Top level of the doubly linked deque with handle removal.
// Each transfer on req is one operation and yields exactly one rsp transfer. The node links and
// data live in three synchronous RAMs with one read and one write port each. A push steps through
// accept, write the new node, link the neighbour and respond, and a pop or a remove through accept,
// read the target node, relink its neighbours and respond; a rejected or ignored operation goes
// from accept straight to respond. The respond step holds until rsp ready, and only one operation
// is in flight at a time. Used flags sit in flip-flops, so reset clears the pool at once and a push
// finds the lowest free slot by a priority search.
module linked_deque_with_handle_remove_top #(
   parameter int POOL_DEPTH = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   ldq_req_if.sink   req,
   ldq_rsp_if.source rsp
);
   import ldq_pkg::*;

   localparam int AW = $clog2(POOL_DEPTH);
   localparam int HW = $clog2(POOL_DEPTH + 1);
   localparam logic [HW-1:0] NULL_SLOT = HW'(POOL_DEPTH);

   state_type            state_ff, state_in;
   logic [2:0]           op_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [HW-1:0]        tgt_ff, tgt_in;
   logic [HW-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [HW-1:0]        cnt_ff, cnt_in;
   logic [POOL_DEPTH-1:0] used_ff, used_in;
   status_type           st_ff, st_in;
   logic [HW-1:0]        nh_ff, nh_in;
   logic [DATA_WIDTH-1:0] pv_ff, pv_in;

   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] data_rd;
   logic [HW-1:0]         next_rd, prev_rd;
   logic                  nx_we, pv_we, dt_we;
   logic [AW-1:0]         nx_wa, pv_wa, dt_wa;
   logic [HW-1:0]         nx_wd, pv_wd;
   logic [HW-1:0]         free_slot;
   logic                  step2_ff, step2_in;

   ldq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_data (
      .clock, .wr_en(dt_we), .wr_addr(dt_wa), .wr_data(val_ff),
      .rd_addr, .rd_data(data_rd));
   ldq_ram #(.WIDTH(HW), .DEPTH(POOL_DEPTH)) u_next (
      .clock, .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr, .rd_data(next_rd));
   ldq_ram #(.WIDTH(HW), .DEPTH(POOL_DEPTH)) u_prev (
      .clock, .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_addr, .rd_data(prev_rd));

   always_comb begin
      free_slot = NULL_SLOT;
      for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = HW'(i);
         end
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.popped_value = 32'(pv_ff);
   assign rsp.new_handle = nh_ff;
   assign rsp.status = st_ff;
   assign rsp.count = cnt_ff;
   assign rsp.is_empty = (cnt_ff == '0);
   assign rd_addr = tgt_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      tgt_in = tgt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in = cnt_ff;
      used_in = used_ff;
      st_in = st_ff;
      nh_in = nh_ff;
      pv_in = pv_ff;
      step2_in = step2_ff;
      nx_we = 1'b0; pv_we = 1'b0; dt_we = 1'b0;
      nx_wa = tgt_ff[AW-1:0]; pv_wa = tgt_ff[AW-1:0]; dt_wa = tgt_ff[AW-1:0];
      nx_wd = NULL_SLOT; pv_wd = NULL_SLOT;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               st_in = ST_OK;
               nh_in = NULL_SLOT;
               pv_in = '0;
               state_in = S_OUT;
               case (req.opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (free_slot == NULL_SLOT) begin
                        st_in = ST_FULL;
                     end else begin
                        tgt_in = free_slot;
                        state_in = S_WRITE;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     tgt_in = (req.opcode == OP_POP_FRONT) ? head_ff : tail_ff;
                     if (cnt_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_REMOVE: begin
                     if (32'(req.handle) >= POOL_DEPTH) begin
                        st_in = ST_BAD_HANDLE;
                     end else if (!used_ff[req.handle[AW-1:0]]) begin
                        st_in = ST_BAD_HANDLE;
                     end else begin
                        tgt_in = HW'(req.handle);
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            state_in = S_LINK;
         end
         S_LINK: begin
            if (op_ff != OP_REMOVE) begin
               pv_in = data_rd;
            end
            if (prev_rd != NULL_SLOT) begin
               nx_we = 1'b1; nx_wa = prev_rd[AW-1:0]; nx_wd = next_rd;
            end else begin
               head_in = next_rd;
            end
            if (next_rd != NULL_SLOT) begin
               pv_we = 1'b1; pv_wa = next_rd[AW-1:0]; pv_wd = prev_rd;
            end else begin
               tail_in = prev_rd;
            end
            used_in[tgt_ff[AW-1:0]] = 1'b0;
            cnt_in = cnt_ff - 1'b1;
            state_in = S_OUT;
         end
         S_WRITE: begin
            dt_we = 1'b1;
            used_in[tgt_ff[AW-1:0]] = 1'b1;
            nh_in = tgt_ff;
            if (!step2_ff) begin
               nx_we = 1'b1; pv_we = 1'b1;
               if (op_ff == OP_PUSH_FRONT) begin
                  pv_wd = NULL_SLOT; nx_wd = head_ff;
               end else begin
                  nx_wd = NULL_SLOT; pv_wd = tail_ff;
               end
               step2_in = 1'b1;
            end else begin
               step2_in = 1'b0;
               if (op_ff == OP_PUSH_FRONT) begin
                  if (head_ff != NULL_SLOT) begin
                     pv_we = 1'b1; pv_wa = head_ff[AW-1:0]; pv_wd = tgt_ff;
                  end else begin
                     tail_in = tgt_ff;
                  end
                  head_in = tgt_ff;
               end else begin
                  if (tail_ff != NULL_SLOT) begin
                     nx_we = 1'b1; nx_wa = tail_ff[AW-1:0]; nx_wd = tgt_ff;
                  end else begin
                     head_in = tgt_ff;
                  end
                  tail_in = tgt_ff;
               end
               cnt_in = cnt_ff + 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= NULL_SLOT;
         tail_ff <= NULL_SLOT;
         cnt_ff <= '0;
         used_ff <= '0;
         step2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
         used_ff <= used_in;
         step2_ff <= step2_in;
      end
      if (state_ff == S_IDLE && req.valid) begin
         op_ff <= req.opcode;
         val_ff <= DATA_WIDTH'(unsigned'(req.value));
      end
      tgt_ff <= tgt_in;
      st_ff <= st_in;
      nh_ff <= nh_in;
      pv_ff <= pv_in;
   end
endmodule

// ===== src/ldq_checker.sv =====
// Port-level assertions for the linked deque, bound to its top level.
module ldq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [4:0]  rsp_count,
   input logic        rsp_is_empty,
   input logic [4:0]  rsp_new_handle
);
   import ldq_pkg::*;

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == 5'd0)))
      else $error("is_empty disagrees with count");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !rsp_valid)
      else $error("request taken while a response waits");

   a_handle_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_new_handle == 5'd16))
      else $error("handle given on a failed operation");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_count))
      else $error("response dropped while stalled");
endmodule

bind linked_deque_with_handle_remove_top ldq_checker u_ldq_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_count(rsp.count),
   .rsp_is_empty(rsp.is_empty), .rsp_new_handle(rsp.new_handle)
);
